@@ hw/rtl/tqs_pkg.sv @@
// Shared types, constants and helpers of the tone queue sequencer.
package tqs_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int PENDING_W   = 7;

	// Field widths
	localparam int ACTION_W = 2;
	localparam int FREQ_W   = 16;
	localparam int DUR_W    = 16;
	localparam int DIV_W    = 16;

	// Actions
	localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_STOP    = 2'd2;

	// Tone divisor arithmetic: TIMER_CLK_HZ / clamp(f, FREQ_MIN, FREQ_MAX)
	localparam int DIVIDEND_W = 21;
	localparam int DEN_W      = 15;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam logic [DIVIDEND_W-1:0] TIMER_CLK_HZ = 21'd1193182;
	localparam logic [FREQ_W-1:0]     FREQ_MIN     = 16'd20;
	localparam logic [FREQ_W-1:0]     FREQ_MAX     = 16'd20000;
	localparam logic [DIV_W-1:0]      DIV_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [FREQ_W-1:0]   freq_hz;
		logic [DUR_W-1:0]    length_ms;
	} tqs_cmd_t;

	typedef struct packed {
		logic                 accepted;
		logic                 tone_on;
		logic [DIV_W-1:0]     divisor;
		logic                 load_pulse;
		logic [PENDING_W-1:0] pending;
	} tqs_rsp_t;

	// One queue entry as stored in the event memory
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
	} tqs_event_t;

	localparam int EVENT_W = $bits(tqs_event_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} tqs_state_t;

	function automatic logic [DEN_W-1:0] clamp_freq(input logic [FREQ_W-1:0] f);
		logic [FREQ_W-1:0] c;
		c = f;
		if (c < FREQ_MIN) c = FREQ_MIN;
		if (c > FREQ_MAX) c = FREQ_MAX;
		return c[DEN_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

endpackage

@@ hw/rtl/tqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/tqs_div.sv @@
// Bit-serial restoring divider for the tone timer divisor.
module tqs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tqs_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [tqs_pkg::DIV_W-1:0] quot
);
	import tqs_pkg::*;

	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DEN_W:0] trial;
	logic           fits;
	logic [DEN_W:0] diff;

	// One quotient bit per cycle: shift in the next dividend bit, try to subtract
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= TIMER_CLK_HZ;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	// Clamp the quotient into the timer's 1..65535 range
	always_comb begin
		if (quo_q == '0) begin
			quot = DIV_W'(1);
		end else if (quo_q > DIVIDEND_W'(DIV_MAX)) begin
			quot = DIV_MAX;
		end else begin
			quot = quo_q[DIV_W-1:0];
		end
	end

	assign done = done_q;

endmodule

@@ hw/rtl/tone_queue_sequencer.sv @@
// Top level of the tone queue sequencer: event queue, tick sequencing and response port.
//
// Tone events (frequency in Hz, length in ms) are queued in a 64-entry event
// memory and played in order. Each command beat is one action: enqueue (rejected
// when the length is zero or the queue is full), a one-millisecond tick, or stop,
// which empties the queue and silences the speaker. A tick first counts the
// active tone down and ends it at zero; if no tone is then active and the queue
// holds an event, the event is popped and started. A zero frequency plays
// silence; any other frequency is clamped to 20..20000 Hz and the timer divisor
// 1193182 / f (clamped to 1..65535) is computed. Every command beat yields exactly
// one response beat carrying the gate state, the sounding divisor, a start pulse
// and the pending count (queued events plus the active one, modulo 128).
// A tick that starts a tone reads the event memory and then runs the 21-step
// bit-serial divider before its response is loaded; a tick that starts a
// silence event reads the memory but skips the divide. A finished response sits
// in an output register, so the block accepts the next command while the
// response waits to be taken.
module tone_queue_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  tqs_pkg::tqs_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tqs_pkg::tqs_rsp_t rsp
);
	import tqs_pkg::*;

	tqs_state_t state_q, state_d;

	// Queue and tone state
	logic [PTR_W-1:0] rp_q, wp_q;
	logic [CNT_W-1:0] fill_q;
	logic             act_q;
	logic [DUR_W-1:0] rem_q;
	logic             gate_q;
	logic [DIV_W-1:0] div_q;

	// Per-beat result flags
	logic acc_q;
	logic load_q;

	// Response register
	logic     rsp_valid_q;
	tqs_rsp_t rsp_q;

	// Event memory
	logic             mem_we, mem_re;
	logic [EVENT_W-1:0] mem_rdata;
	tqs_event_t       ev_rd;
	tqs_event_t       ev_wr;

	// Divider
	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;

	// Command decode and tick countdown
	logic             cmd_fire;
	logic             enq_ok;
	logic             act_tick;
	logic [DUR_W-1:0] rem_tick;
	logic             end_tone;
	logic             pop_go;
	logic             rsp_load;
	logic [CNT_W:0]   pending_sum;

	assign cmd_fire = cmd_valid && !cmd_stall;
	assign enq_ok   = (cmd.length_ms != '0) && (fill_q != CNT_W'(QUEUE_DEPTH));
	assign ev_rd    = tqs_event_t'(mem_rdata);
	assign ev_wr    = '{freq: cmd.freq_hz, dur: cmd.length_ms};

	// Count the active tone down first; a tone at one or zero ends on this tick
	always_comb begin
		act_tick = act_q;
		rem_tick = rem_q;
		end_tone = 1'b0;
		if (act_q) begin
			if (rem_q <= DUR_W'(1)) begin
				act_tick = 1'b0;
				rem_tick = '0;
				end_tone = 1'b1;
			end else begin
				rem_tick = rem_q - DUR_W'(1);
			end
		end
		pop_go = !act_tick && (fill_q != '0);
	end

	assign mem_we = cmd_fire && (cmd.action == ACT_ENQUEUE) && enq_ok;
	assign mem_re = cmd_fire && (cmd.action == ACT_TICK) && pop_go;

	tqs_ram #(
		.WIDTH(EVENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_event_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wp_q),
		.wdata(ev_wr),
		.re   (mem_re),
		.raddr(rp_q),
		.rdata(mem_rdata)
	);

	tqs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.den   (clamp_freq(ev_rd.freq)),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					state_d = mem_re ? ST_READ : ST_DONE;
				end
			end
			ST_READ: begin
				state_d = (ev_rd.freq == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State machine outputs
	always_comb begin
		cmd_stall = 1'b1;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd_stall = 1'b0;
			ST_READ: div_start = (ev_rd.freq != '0);
			ST_DIV:  ;
			ST_DONE: rsp_load = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Queue pointers, fill count and tone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			act_q  <= 1'b0;
			rem_q  <= '0;
			gate_q <= 1'b0;
			div_q  <= '0;
			acc_q  <= 1'b0;
			load_q <= 1'b0;
		end else if (cmd_fire) begin
			acc_q  <= 1'b0;
			load_q <= 1'b0;
			unique case (cmd.action)
				ACT_ENQUEUE: begin
					if (enq_ok) begin
						wp_q   <= next_ptr(wp_q);
						fill_q <= fill_q + CNT_W'(1);
						acc_q  <= 1'b1;
					end
				end
				ACT_TICK: begin
					act_q <= act_tick;
					rem_q <= rem_tick;
					if (end_tone) begin
						gate_q <= 1'b0;
						div_q  <= '0;
					end
					// Pop: the duration and divisor follow once the entry is read
					if (pop_go) begin
						rp_q   <= next_ptr(rp_q);
						fill_q <= fill_q - CNT_W'(1);
						act_q  <= 1'b1;
						load_q <= 1'b1;
					end
				end
				ACT_STOP: begin
					rp_q   <= '0;
					wp_q   <= '0;
					fill_q <= '0;
					act_q  <= 1'b0;
					rem_q  <= '0;
					gate_q <= 1'b0;
					div_q  <= '0;
				end
				default: ;
			endcase
		end else if (state_q == ST_READ) begin
			rem_q <= ev_rd.dur;
			// Silence event: gate stays off
			if (ev_rd.freq == '0) begin
				gate_q <= 1'b0;
				div_q  <= '0;
			end
		end else if (div_done) begin
			div_q  <= div_quot;
			gate_q <= 1'b1;
		end
	end

	assign pending_sum = {1'b0, fill_q} + (CNT_W + 1)'(act_q);

	// Response register: hold the beat until the far side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.accepted   <= acc_q;
			rsp_q.tone_on    <= gate_q;
			rsp_q.divisor    <= gate_q ? div_q : '0;
			rsp_q.load_pulse <= load_q;
			rsp_q.pending    <= PENDING_W'(pending_sum);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
